// File: src/rpoc_pkg.sv
// Package for the run-length pattern occurrence counter.
// Holds field widths, operation codes and the controller/datapath interface structs.
// Depends on nothing.
package rpoc_pkg;

  localparam int LEN_W = 20;
  localparam int SYM_W = 8;
  localparam int OCC_W = 64;

  localparam logic [1:0] OP_PATTERN = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  typedef struct packed {
    logic accept;
    logic close;
    logic scan;
    logic drain;
    logic emit;
  } rpoc_cmd_t;

  typedef struct packed {
    logic acc_close;
    logic acc_end;
    logic scan_needed;
    logic scan_last;
    logic out_free;
  } rpoc_sts_t;

endpackage

// File: src/rle_pattern_occurrence_counter_unit.sv
// Top level of the run-length pattern occurrence counter.
// Depends on rpoc_pkg, rpoc_ctrl and rpoc_datapath.
//
//   Channel  Handshake                  Beat contents
//   item     item_valid / item_ready    op, run_length, symbol
//   result   result_valid / result_ready occurrences, pattern_overflow
//
// A pattern run, a text run that closes nothing or an ignored item is taken in S_IDLE alone.
// A text run that closes the open run passes through S_CLOSE, or through S_CLOSE, S_SCAN
// and S_DRAIN once a P-run pattern (P >= 2, not overflowed) has P closed text runs to
// scan against. An end beat adds S_EMIT to write the result register; it waits while full.
// Reset is synchronous and needs no clearing pass; the result register decouples the outlet.
module rle_pattern_occurrence_counter_unit
  import rpoc_pkg::*;
#(
  parameter int MAX_PATTERN_RUNS = 64,
  parameter int RUN_COUNT_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [1:0]       op,
  input  logic [LEN_W-1:0] run_length,
  input  logic [SYM_W-1:0] symbol,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [OCC_W-1:0] occurrences,
  output logic             pattern_overflow
);

  rpoc_cmd_t cmd;
  rpoc_sts_t sts;

  rpoc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rpoc_datapath #(
    .MAX_PATTERN_RUNS (MAX_PATTERN_RUNS),
    .RUN_COUNT_BITS   (RUN_COUNT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .op               (op),
    .run_length       (run_length),
    .symbol           (symbol),
    .occurrences      (occurrences),
    .pattern_overflow (pattern_overflow),
    .result_valid     (result_valid),
    .result_ready     (result_ready)
  );

endmodule

// File: src/rpoc_ctrl.sv
// Controller state machine of the run-length pattern occurrence counter.
// Depends on rpoc_pkg for the command and status structs.
module rpoc_ctrl
  import rpoc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  rpoc_sts_t sts,
  output rpoc_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLOSE = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic end_pending, end_pending_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.accept = item_valid && (state == S_IDLE);
    cmd.close  = (state == S_CLOSE);
    cmd.scan   = (state == S_SCAN);
    cmd.drain  = (state == S_DRAIN);
    cmd.emit   = (state == S_EMIT) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    end_pending_next = end_pending;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          end_pending_next = sts.acc_end;
          if (sts.acc_close) begin
            state_next = S_CLOSE;
          end else if (sts.acc_end) begin
            state_next = S_EMIT;
          end
        end
      end
      S_CLOSE: begin
        if (sts.scan_needed) begin
          state_next = S_SCAN;
        end else if (end_pending) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = end_pending ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
          end_pending_next = 1'b0;
        end
      end
      default: begin
        state_next = S_IDLE;
        end_pending_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      end_pending <= 1'b0;
    end else begin
      state <= state_next;
      end_pending <= end_pending_next;
    end
  end

endmodule

// File: src/rpoc_datapath.sv
// Datapath of the run-length pattern occurrence counter: pattern and text run
// memories, open run, window compare and match total. Depends on rpoc_pkg.
module rpoc_datapath
  import rpoc_pkg::*;
#(
  parameter int MAX_PATTERN_RUNS = 64,
  parameter int RUN_COUNT_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  rpoc_cmd_t        cmd,
  output rpoc_sts_t        sts,
  input  logic [1:0]       op,
  input  logic [LEN_W-1:0] run_length,
  input  logic [SYM_W-1:0] symbol,
  output logic [OCC_W-1:0] occurrences,
  output logic             pattern_overflow,
  output logic             result_valid,
  input  logic             result_ready
);

  localparam int RCB   = RUN_COUNT_BITS;
  localparam int ENT_W = RCB + SYM_W;
  localparam int IDX_W = (MAX_PATTERN_RUNS > 1) ? $clog2(MAX_PATTERN_RUNS) : 1;
  localparam int CNT_W = $clog2(MAX_PATTERN_RUNS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PATTERN_RUNS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PATTERN_RUNS - 1);
  localparam logic [CNT_W:0]   MAX_EXT  = (CNT_W + 1)'(MAX_PATTERN_RUNS);

  function automatic logic [RCB-1:0] sat_add(input logic [RCB-1:0] a,
                                             input logic [RCB-1:0] b);
    logic [RCB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RCB] ? {RCB{1'b1}} : s[RCB-1:0];
  endfunction

  logic [ENT_W-1:0] pmem [MAX_PATTERN_RUNS];
  logic [ENT_W-1:0] tmem [MAX_PATTERN_RUNS];

  logic [CNT_W-1:0] p_total;
  logic             too_long;
  logic             loading;
  logic [RCB-1:0]   first_len, last_len;
  logic [SYM_W-1:0] first_sym, last_sym;
  logic             open_valid;
  logic [RCB-1:0]   open_len;
  logic [SYM_W-1:0] open_sym;
  logic [RCB-1:0]   cl_len;
  logic [SYM_W-1:0] cl_sym;
  logic [IDX_W-1:0] wptr;
  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] k, tidx, rd_k;
  logic             rd_valid;
  logic             ok;
  logic [ENT_W-1:0] p_rd, t_rd;
  logic [OCC_W-1:0] match;

  logic [RCB-1:0]   run_ext;
  logic             len_nz;
  logic             pat_do, pat_merge, pat_new, text_do, text_merge;
  logic [CNT_W-1:0] p_top, pm1, fill_next;
  logic [RCB-1:0]   merged_len;
  logic             pw_en;
  logic [IDX_W-1:0] pw_addr;
  logic [ENT_W-1:0] pw_data;
  logic [CNT_W:0]   wp_ext, pm1_ext, start;
  logic             single_hit, cmp_ok;
  logic             p_first, p_last;
  logic [RCB-1:0]   rp_len, rt_len;
  logic [SYM_W-1:0] rp_sym, rt_sym;
  logic [RCB:0]     add_amt;
  logic             add_en;
  logic [OCC_W:0]   match_sum;
  logic [OCC_W-1:0] match_next;

  assign run_ext    = RCB'(run_length);
  assign len_nz     = (run_length != '0);
  assign p_top      = p_total - CNT_W'(1);
  assign pm1        = p_top;
  assign pat_do     = cmd.accept && (op == OP_PATTERN) && len_nz && !loading && !too_long;
  assign pat_merge  = pat_do && (p_total != '0) && (last_sym == symbol);
  assign pat_new    = pat_do && !pat_merge && (p_total < MAX_CNT);
  assign merged_len = sat_add(last_len, run_ext);
  assign text_do    = cmd.accept && (op == OP_TEXT) && len_nz;
  assign text_merge = open_valid && (open_sym == symbol);

  always_comb begin
    pw_en   = pat_merge || pat_new;
    pw_addr = pat_merge ? p_top[IDX_W-1:0] : p_total[IDX_W-1:0];
    pw_data = pat_merge ? {merged_len, symbol} : {run_ext, symbol};
  end

  assign fill_next = (fill == MAX_CNT) ? fill : fill + CNT_W'(1);
  assign wp_ext    = (CNT_W + 1)'(wptr);
  assign pm1_ext   = (CNT_W + 1)'(pm1);
  assign start     = (wp_ext >= pm1_ext) ? (wp_ext - pm1_ext) : (wp_ext + MAX_EXT - pm1_ext);

  assign sts.acc_close   = ((op == OP_TEXT) && len_nz && open_valid && (open_sym != symbol))
                           || ((op == OP_END) && open_valid);
  assign sts.acc_end     = (op == OP_END);
  assign sts.scan_needed = !too_long && (p_total >= CNT_W'(2)) && (fill_next >= p_total);
  assign sts.scan_last   = (CNT_W'(k) == pm1);
  assign sts.out_free    = !result_valid || result_ready;

  assign single_hit = cmd.close && !too_long && (p_total == CNT_W'(1))
                      && (cl_sym == first_sym) && (cl_len >= first_len);

  assign {rp_len, rp_sym} = p_rd;
  assign {rt_len, rt_sym} = t_rd;
  assign p_first = (rd_k == '0);
  assign p_last  = (CNT_W'(rd_k) == pm1);

  always_comb begin
    if (p_first || p_last) begin
      cmp_ok = (rt_sym == rp_sym) && (rt_len >= rp_len);
    end else begin
      cmp_ok = (rt_sym == rp_sym) && (rt_len == rp_len);
    end
  end

  always_comb begin
    add_en  = single_hit || (cmd.drain && ok && cmp_ok);
    add_amt = single_hit ? ((RCB + 1)'(cl_len - first_len) + (RCB + 1)'(1))
                         : (RCB + 1)'(1);
    match_sum  = {1'b0, match} + (OCC_W + 1)'(add_amt);
    match_next = match_sum[OCC_W] ? {OCC_W{1'b1}} : match_sum[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      pmem[pw_addr] <= pw_data;
    end
    p_rd <= pmem[k];
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      tmem[wptr] <= {cl_len, cl_sym};
    end
    t_rd <= tmem[tidx];
  end

  always_ff @(posedge clk) begin
    if (pat_merge) begin
      last_len <= merged_len;
      if (p_total == CNT_W'(1)) begin
        first_len <= merged_len;
      end
    end else if (pat_new) begin
      last_len <= run_ext;
      last_sym <= symbol;
      if (p_total == '0) begin
        first_len <= run_ext;
        first_sym <= symbol;
      end
    end
    if (text_do) begin
      if (text_merge) begin
        open_len <= sat_add(open_len, run_ext);
      end else begin
        open_len <= run_ext;
        open_sym <= symbol;
      end
    end
    if (cmd.accept && sts.acc_close) begin
      cl_len <= open_len;
      cl_sym <= open_sym;
    end
    if (cmd.close) begin
      k    <= '0;
      tidx <= start[IDX_W-1:0];
      ok   <= 1'b1;
    end else if (cmd.scan) begin
      k    <= k + IDX_W'(1);
      tidx <= (tidx == LAST_IDX) ? '0 : tidx + IDX_W'(1);
    end
    if (rd_valid && cmd.scan) begin
      ok <= ok && cmp_ok;
    end
    rd_k <= k;
    if (cmd.emit) begin
      occurrences      <= too_long ? '0 : match;
      pattern_overflow <= too_long;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_total      <= '0;
      too_long     <= 1'b0;
      loading      <= 1'b0;
      open_valid   <= 1'b0;
      fill         <= '0;
      wptr         <= '0;
      match        <= '0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan;
      if (cmd.emit) begin
        result_valid <= 1'b1;
        p_total      <= '0;
        too_long     <= 1'b0;
        loading      <= 1'b0;
        open_valid   <= 1'b0;
        fill         <= '0;
        wptr         <= '0;
        match        <= '0;
      end else begin
        if (result_ready) begin
          result_valid <= 1'b0;
        end
        if (pat_new) begin
          p_total <= p_total + CNT_W'(1);
        end else if (pat_do && !pat_merge) begin
          too_long <= 1'b1;
        end
        if (text_do) begin
          loading    <= 1'b1;
          open_valid <= 1'b1;
        end else if (cmd.accept && (op == OP_END)) begin
          open_valid <= 1'b0;
        end
        if (cmd.close) begin
          fill <= fill_next;
          wptr <= (wptr == LAST_IDX) ? '0 : wptr + IDX_W'(1);
        end
        if (add_en) begin
          match <= match_next;
        end
      end
    end
  end

endmodule

// File: src/rpoc_checker.sv
// Port-level checker for the run-length pattern occurrence counter, bound to the top level.
// Depends on rpoc_pkg.
module rpoc_checker
  import rpoc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic [1:0]       op,
  input logic [LEN_W-1:0] run_length,
  input logic [SYM_W-1:0] symbol,
  input logic             result_valid,
  input logic             result_ready,
  input logic [OCC_W-1:0] occurrences,
  input logic             pattern_overflow
);

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(op))
    else $error("item beat dropped before acceptance");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(occurrences))
    else $error("result beat changed while stalled");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && pattern_overflow |-> occurrences == '0)
    else $error("overflowed pattern reported nonzero occurrences");

  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && op == OP_END |=> !item_ready)
    else $error("item taken right after an end beat");

endmodule

bind rle_pattern_occurrence_counter_unit rpoc_checker u_rpoc_checker (.*);

// File: tb/sv/rpoc_occurrence_checker.sv
`timescale 1ns / 1ps
// Checker for the run-length pattern occurrence counter: watches the item and result
// channels, predicts every end-of-text report and compares it field by field.
// Depends on rpoc_pkg.
module rpoc_occurrence_checker
  import rpoc_pkg::*;
#(
  parameter int MAX_RUNS = 64,
  parameter int CNT_W    = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  logic [1:0]       op,
  input  logic [LEN_W-1:0] run_length,
  input  logic [SYM_W-1:0] symbol,
  input  logic             result_valid,
  input  logic             result_ready,
  input  logic [OCC_W-1:0] occurrences,
  input  logic             pattern_overflow,
  output int               mismatches,
  output int               reports_pending
);

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [SYM_W-1:0] sym;
  } run_t;

  typedef struct packed {
    logic [OCC_W-1:0] occ;
    logic             ovf;
  } report_t;

  run_t             pat_runs [MAX_RUNS];
  int               pat_count;
  bit               pat_overflow;
  run_t             text_window [MAX_RUNS];
  int               window_fill;
  bit               open_valid;
  run_t             open_run;
  logic [OCC_W-1:0] match_total;
  bit               text_started;
  report_t          expected_reports [$];

  function automatic logic [CNT_W-1:0] merge_len(input logic [CNT_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
    logic [CNT_W:0] s;
    s = a + b;
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  task automatic add_matches(input logic [OCC_W-1:0] n);
    logic [OCC_W:0] s;
    s = match_total + n;
    match_total = s[OCC_W] ? '1 : s[OCC_W-1:0];
  endtask

  task automatic clear_counter();
    for (int i = 0; i < MAX_RUNS; i++) begin
      pat_runs[i] = '0;
      text_window[i] = '0;
    end
    pat_count = 0;
    pat_overflow = 0;
    window_fill = 0;
    open_valid = 0;
    open_run = '0;
    match_total = '0;
    text_started = 0;
  endtask

  task automatic close_text_run();
    int p;
    int base;
    bit hit;
    p = pat_count;
    if (!open_valid) return;
    open_valid = 0;
    if (window_fill < MAX_RUNS) begin
      text_window[window_fill] = open_run;
      window_fill++;
    end else begin
      for (int i = 0; i < MAX_RUNS - 1; i++) text_window[i] = text_window[i + 1];
      text_window[MAX_RUNS - 1] = open_run;
    end
    if (pat_overflow || p == 0 || window_fill < p) return;
    if (p == 1) begin
      if (open_run.sym == pat_runs[0].sym && open_run.len >= pat_runs[0].len)
        add_matches(OCC_W'(open_run.len - pat_runs[0].len) + 1);
      return;
    end
    base = window_fill - p;
    hit = text_window[base].sym == pat_runs[0].sym &&
          text_window[base].len >= pat_runs[0].len &&
          text_window[base + p - 1].sym == pat_runs[p - 1].sym &&
          text_window[base + p - 1].len >= pat_runs[p - 1].len;
    for (int k = 1; k + 1 < p; k++) begin
      if (text_window[base + k] != pat_runs[k]) hit = 0;
    end
    if (hit) add_matches(1);
  endtask

  task automatic count_beat(input logic [1:0] code, input logic [LEN_W-1:0] len,
                            input logic [SYM_W-1:0] sym);
    report_t rep;
    case (code)
      OP_PATTERN: begin
        if (len != 0 && !text_started && !pat_overflow) begin
          if (pat_count > 0 && pat_runs[pat_count - 1].sym == sym) begin
            pat_runs[pat_count - 1].len = merge_len(pat_runs[pat_count - 1].len, len);
          end else if (pat_count < MAX_RUNS) begin
            pat_runs[pat_count].len = CNT_W'(len);
            pat_runs[pat_count].sym = sym;
            pat_count++;
          end else begin
            pat_overflow = 1;
          end
        end
      end
      OP_TEXT: begin
        if (len != 0) begin
          text_started = 1;
          if (open_valid && open_run.sym == sym) begin
            open_run.len = merge_len(open_run.len, len);
          end else begin
            close_text_run();
            open_valid = 1;
            open_run.len = CNT_W'(len);
            open_run.sym = sym;
          end
        end
      end
      OP_END: begin
        close_text_run();
        rep.occ = pat_overflow ? '0 : match_total;
        rep.ovf = pat_overflow;
        expected_reports = {expected_reports, rep};
        clear_counter();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    report_t want;
    if (rst) begin
      clear_counter();
      expected_reports.delete();
      mismatches = 0;
    end else begin
      if (item_valid && item_ready) count_beat(op, run_length, symbol);
      if (result_valid && result_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got occurrences %0d overflow %0b",
                   $time, occurrences, pattern_overflow);
        end else begin
          want = expected_reports.pop_front();
          if (occurrences !== want.occ) begin
            mismatches++;
            $display("%0t: occurrences expected %0d, got %0d", $time, want.occ, occurrences);
          end
          if (pattern_overflow !== want.ovf) begin
            mismatches++;
            $display("%0t: pattern_overflow expected %0b, got %0b",
                     $time, want.ovf, pattern_overflow);
          end
        end
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the occurrence counter testbench: clock, reset, item and result stimulus.
// Depends on rpoc_pkg, rle_pattern_occurrence_counter_unit and rpoc_occurrence_checker.
module testbench;
  import rpoc_pkg::*;

  localparam int MAX_RUNS = 64;
  localparam int CNT_W = 32;
  localparam int RANDOM_BEATS = 1400;
  localparam int SAT_RUNS = 24;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  logic [1:0]       op = OP_PATTERN;
  logic [LEN_W-1:0] run_length = '0;
  logic [SYM_W-1:0] symbol = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic [OCC_W-1:0] occurrences;
  logic             pattern_overflow;
  int               mismatches;
  int               reports_pending;

  bit quiet = 0;
  int total_beats = 0;
  int reports_sent = 0;

  always #1 clk = ~clk;

  rle_pattern_occurrence_counter_unit #(
    .MAX_PATTERN_RUNS(MAX_RUNS),
    .RUN_COUNT_BITS  (CNT_W)
  ) i_dut (.*);

  rpoc_occurrence_checker #(
    .MAX_RUNS(MAX_RUNS),
    .CNT_W   (CNT_W)
  ) i_checker (.*);

  always @(negedge clk) begin
    result_ready <= quiet || ($urandom_range(99) >= 33);
  end

  task automatic send_beat(input logic [1:0] code, input logic [LEN_W-1:0] len,
                           input logic [SYM_W-1:0] sym);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 33) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    op <= code;
    run_length <= len;
    symbol <= sym;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    total_beats++;
    if (code == OP_END) reports_sent++;
  endtask

  initial begin
    logic [SYM_W-1:0] alph [4];
    logic [LEN_W-1:0] plen [MAX_RUNS + 8];
    logic [SYM_W-1:0] psym [MAX_RUNS + 8];
    int alpha;
    int np;
    int nseg;
    int pick;
    int extra;
    int seq;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Text with no pattern loaded.
    send_beat(OP_TEXT, 5, 8'h61);
    send_beat(OP_END, 0, 0);

    // One-run pattern with merging, zero-length runs, a late pattern run and a spare op.
    send_beat(OP_PATTERN, 2, 8'h61);
    send_beat(OP_PATTERN, 1, 8'h61);
    send_beat(OP_PATTERN, 0, 8'h62);
    send_beat(OP_TEXT, 4, 8'h61);
    send_beat(OP_TEXT, 3, 8'h61);
    send_beat(OP_TEXT, 0, 8'h62);
    send_beat(OP_TEXT, 2, 8'h62);
    send_beat(OP_TEXT, 3, 8'h61);
    send_beat(OP_PATTERN, 1, 8'h61);
    send_beat(OP_SPARE, LEN_MAX, 8'hFF);
    send_beat(OP_END, 0, 0);

    // Three-run pattern at the field extremes.
    send_beat(OP_PATTERN, LEN_MAX, 8'hFF);
    send_beat(OP_PATTERN, 1, 8'h00);
    send_beat(OP_PATTERN, LEN_MAX, 8'hFF);
    send_beat(OP_TEXT, LEN_MAX, 8'hFF);
    send_beat(OP_TEXT, 1, 8'h00);
    send_beat(OP_TEXT, LEN_MAX, 8'hFF);
    send_beat(OP_TEXT, 1, 8'h00);
    send_beat(OP_TEXT, LEN_MAX, 8'hFF);
    send_beat(OP_END, 0, 0);

    // Long pattern and text runs merged from many full-length beats.
    quiet = 1;
    repeat (SAT_RUNS) send_beat(OP_PATTERN, LEN_MAX, 8'h5A);
    repeat (SAT_RUNS) send_beat(OP_TEXT, LEN_MAX, 8'h5A);
    send_beat(OP_END, 0, 0);
    quiet = 0;

    seq = 0;
    while (total_beats < RANDOM_BEATS) begin
      quiet = (seq >= 12 && seq < 20);
      seq++;
      alpha = $urandom_range(2, 4);
      alph[0] = SYM_W'($urandom);
      for (int i = 1; i < 4; i++) alph[i] = SYM_W'(alph[0] + i * $urandom_range(1, 63));
      pick = $urandom_range(99);
      if (pick < 70) begin
        np = ($urandom_range(99) < 8) ? $urandom_range(5, MAX_RUNS) : $urandom_range(1, 4);
        for (int i = 0; i < np; i++) begin
          pick = $urandom_range(0, alpha - 1);
          if (i > 0 && alph[pick] == psym[i - 1]) pick = (pick + 1) % alpha;
          psym[i] = alph[pick];
          plen[i] = LEN_W'($urandom_range(1, 4));
        end
        for (int i = 0; i < np; i++) begin
          if ($urandom_range(15) == 0) send_beat(OP_PATTERN, '0, SYM_W'($urandom));
          if (plen[i] > 1 && $urandom_range(3) == 0) begin
            send_beat(OP_PATTERN, plen[i] - LEN_W'(1), psym[i]);
            send_beat(OP_PATTERN, 1, psym[i]);
          end else begin
            send_beat(OP_PATTERN, plen[i], psym[i]);
          end
        end
        nseg = (np > 4) ? $urandom_range(1, 3) : $urandom_range(2, 10);
        for (int s = 0; s < nseg; s++) begin
          if ($urandom_range(1) == 1) begin
            for (int i = 0; i < np; i++) begin
              if (i == 0 || i == np - 1) extra = $urandom_range(0, 2);
              else extra = ($urandom_range(9) == 0) ? 1 : 0;
              send_beat(OP_TEXT, plen[i] + LEN_W'(extra), psym[i]);
            end
          end else begin
            repeat ($urandom_range(1, 4))
              send_beat(OP_TEXT, LEN_W'($urandom_range(1, 5)),
                        alph[$urandom_range(0, alpha - 1)]);
          end
        end
        if ($urandom_range(7) == 0)
          send_beat(OP_PATTERN, LEN_W'($urandom_range(1, 5)), alph[0]);
      end else if (pick < 80) begin
        np = $urandom_range(MAX_RUNS, MAX_RUNS + 4);
        for (int i = 0; i < np; i++) begin
          psym[i] = alph[i % 2];
          plen[i] = LEN_W'($urandom_range(1, 3));
          send_beat(OP_PATTERN, plen[i], psym[i]);
        end
        for (int i = 0; i < MAX_RUNS; i++) send_beat(OP_TEXT, plen[i], psym[i]);
      end else begin
        repeat ($urandom_range(3, 20))
          send_beat(2'($urandom_range(0, 3)),
                    ($urandom_range(7) == 0) ? '0 : LEN_W'($urandom_range(0, LEN_MAX)),
                    SYM_W'($urandom));
      end
      send_beat(OP_END, 0, 0);
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);

    $display("Sent %0d item beats and checked %0d end-of-text reports, covering", total_beats,
             reports_sent);
    $display("empty, long merged and overflowed patterns plus random matching sessions.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
